// File: rtl/core/tfb_pkg.sv
// Shared constants and types for the telemetry frame builder.
package tfb_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] ADDR_RESET  = 8'hFF;
  localparam logic [7:0] CODE_F1     = 8'hF1;
  localparam logic [7:0] CODE_F2     = 8'hF2;
  localparam logic [7:0] LEN_F1      = 8'd7;
  localparam logic [7:0] LEN_F2      = 8'd8;

  localparam logic [3:0] POS_HEADER  = 4'd0;
  localparam logic [3:0] POS_ADDR    = 4'd1;
  localparam logic [3:0] POS_CODE    = 4'd2;
  localparam logic [3:0] POS_LEN     = 4'd3;
  localparam logic [3:0] POS_CHK_F1  = 4'd11;
  localparam logic [3:0] POS_CHK_F2  = 4'd12;
  localparam logic [3:0] POS_LAST_F1 = 4'd12;
  localparam logic [3:0] POS_LAST_F2 = 4'd13;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

endpackage

// File: rtl/core/telemetry_frame_builder_unit.sv
// Telemetry frame builder: one request in, a 13- or 14-byte checked frame out.
//
// Each accepted request (kind on in_tuser, four 16-bit values on in_tdata) is
// sent as one frame, one byte per cycle while out_tready is high, through a
// registered output: header, target address, function code, length, payload,
// running sum and sum of running sums. One 8-bit accumulate step per byte
// before the checks updates both checks as the bytes go out. The input
// is not ready while a frame is being sent; the next request can be taken
// while the final byte still waits in the output register.
module telemetry_frame_builder_unit
  import tfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_value, second_value, third_value, fourth_value
  input  logic [7:0]  in_tuser,   // func, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte
  output logic        out_tlast,
  output logic [7:0]  out_tuser   // link_select, zero fill
);

  state_t      state_r, state_nxt;
  logic [7:0]  addr_r;
  logic        kind_r;
  logic [15:0] val_r [4];
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sc_r, sc_nxt;
  logic [7:0]  ac_r, ac_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  od_r;
  logic        ol_r;
  logic        ok_r;

  logic        in_acc;
  logic        load;
  logic [7:0]  byte_sel;
  logic [3:0]  chk_pos;
  logic [3:0]  last_pos;
  logic        is_last;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign load       = (state_r == ST_SEND) && (!ov_r || out_tready);
  assign chk_pos    = kind_r ? POS_CHK_F2 : POS_CHK_F1;
  assign last_pos   = kind_r ? POS_LAST_F2 : POS_LAST_F1;
  assign is_last    = (pos_r == last_pos);

  always_comb begin
    case (pos_r)
      POS_HEADER: byte_sel = HEADER_BYTE;
      POS_ADDR:   byte_sel = addr_r;
      POS_CODE:   byte_sel = kind_r ? CODE_F2 : CODE_F1;
      POS_LEN:    byte_sel = kind_r ? LEN_F2 : LEN_F1;
      4'd4:       byte_sel = val_r[0][7:0];
      4'd5:       byte_sel = val_r[0][15:8];
      4'd6:       byte_sel = val_r[1][7:0];
      4'd7:       byte_sel = val_r[1][15:8];
      4'd8:       byte_sel = val_r[2][7:0];
      4'd9:       byte_sel = val_r[2][15:8];
      4'd10:      byte_sel = val_r[3][7:0];
      4'd11:      byte_sel = kind_r ? val_r[3][15:8] : sc_r;
      4'd12:      byte_sel = kind_r ? sc_r : ac_r;
      default:    byte_sel = ac_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    sc_nxt    = sc_r;
    ac_nxt    = ac_r;
    ov_nxt    = ov_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SEND;
          pos_nxt   = '0;
          sc_nxt    = '0;
          ac_nxt    = '0;
        end
      end
      ST_SEND: begin
        if (load) begin
          ov_nxt  = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (pos_r < chk_pos) begin
            sc_nxt = sc_r + byte_sel;
            ac_nxt = ac_r + (sc_r + byte_sel);
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= ADDR_RESET;
      pos_r   <= '0;
      sc_r    <= '0;
      ac_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      sc_r    <= sc_nxt;
      ac_r    <= ac_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_tuser[0];
      val_r[0] <= in_tdata[15:0];
      val_r[1] <= in_tdata[31:16];
      val_r[2] <= in_tdata[47:32];
      val_r[3] <= in_tdata[63:48];
    end
    if (load) begin
      od_r <= byte_sel;
      ol_r <= is_last;
      ok_r <= kind_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = {7'd0, ok_r};

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SEND) && (pos_r == POS_HEADER))
    else $error("request did not start a frame");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (pos_r <= last_pos))
    else $error("byte position past end of frame");

  a_link_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser[0] == kind_r))
    else $error("link select differs from frame kind");

  a_last_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> (out_tdata == ac_r) && out_tlast)
    else $error("final byte is not the add check");

endmodule
